// ===== design/tew_pkg.sv =====
// Shared types and constants of the transparency edge window.
// No dependencies; tew_pos, tew_classify and transparency_edge_window import this package.
package tew_pkg;

    // Configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_KIND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_MASK = 3'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [1:0]       SELECT_RST = 2'd3;
    localparam logic [7:0]       DIR_RST    = 8'hff;

    // Select kind codes
    localparam logic [1:0] SEL_INNER = 2'd1;
    localparam logic [1:0] SEL_OUTER = 2'd2;
    localparam logic [1:0] SEL_BOTH  = 2'd3;

    localparam logic [CFG_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [3:0]       FULL_COUNT = 4'd9;

    // One line store word: bit 1 upper row, bit 0 middle row
    localparam int LINE_W = 2;

    // Position flags of the centre belonging to one accepted item
    typedef struct packed {
        logic res_valid;
        logic top_cut;
        logic bot_cut;
        logic left_cut;
        logic right_cut;
        logic last;
    } pos_info_t;

endpackage

// ===== design/tew_if.sv =====
// Handshake channels of the transparency edge window: pixel input and result output.
// Standalone; no package needed.
interface tew_pix_if;
    logic valid;
    logic ready;
    logic kind;
    logic transparent;

    modport source (output valid, output kind, output transparent, input ready);
    modport sink   (input valid, input kind, input transparent, output ready);
endinterface

interface tew_res_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic       inner;
    logic [7:0] neighbour_mask;
    logic [3:0] edge_count;
    logic       last;

    modport source (output valid, output matched, output inner, output neighbour_mask,
                    output edge_count, output last, input ready);
    modport sink   (input valid, input matched, input inner, input neighbour_mask,
                    input edge_count, input last, output ready);
endinterface

// ===== design/tew_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// Read during write to the same address returns the old word. No dependencies.
module tew_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tew_pos.sv =====
// Raster position tracker: column/row counters, clamped frame size and the
// edge flags of the centre that each item completes. Uses tew_pkg.
module tew_pos #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        restart,
    input  logic                        step,
    input  logic                        flush,
    input  logic [tew_pkg::CFG_W-1:0]   image_width,
    input  logic [tew_pkg::CFG_W-1:0]   image_height,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output logic                        ignore,
    output logic                        w_is_one,
    output tew_pkg::pos_info_t          info
);
    import tew_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    logic [COL_W-1:0] col_reg, col_next, w_m1;
    logic [CFG_W-1:0] row_reg, row_next, h_eff, h_p1;
    logic [CMP_W-1:0] w_ext;
    logic             col_zero, col_one;

    // Clamp the frame size
    always_comb
    begin
        w_ext = CMP_W'(image_width);
        if (image_width == '0)
            w_m1 = '0;
        else if (w_ext > CMP_W'(MAX_WIDTH))
            w_m1 = COL_W'(MAX_WIDTH - 1);
        else
            w_m1 = COL_W'(w_ext - CMP_W'(1));

        if (image_height == '0)
            h_eff = 13'd1;
        else if (image_height > MAX_HEIGHT)
            h_eff = MAX_HEIGHT;
        else
            h_eff = image_height;
        h_p1 = h_eff + 13'd1;
    end

    assign w_is_one = (w_m1 == '0);
    assign col_zero = (col_reg == '0);
    assign col_one  = (col_reg == COL_W'(1));
    assign col      = col_reg;

    // Flush at the frame's first position does nothing
    assign ignore = flush && col_zero && (row_reg == '0);

    // Centre lags one row and one column; column zero closes the previous row
    always_comb
    begin
        if (col_zero)
        begin
            info.res_valid = (row_reg >= 13'd2) && (row_reg <= h_p1);
            info.top_cut   = (row_reg == 13'd2);
            info.bot_cut   = (row_reg == h_p1);
        end
        else
        begin
            info.res_valid = (row_reg >= 13'd1) && (row_reg <= h_eff);
            info.top_cut   = (row_reg == 13'd1);
            info.bot_cut   = (row_reg == h_eff);
        end
        info.left_cut  = col_one || w_is_one;
        info.right_cut = col_zero;
        info.last      = col_zero && (row_reg == h_p1);
    end

    // Position advance
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (step && !ignore)
        begin
            if (col_zero && (row_reg >= h_p1))
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == w_m1)
            begin
                col_next = '0;
                row_next = row_reg + 13'd1;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== design/tew_classify.sv =====
// Read-data stage and result register: merges the line store word, updates the
// 3x3 window, writes the line stores back and classifies the centre. Uses tew_pkg.
module tew_classify #(
    parameter int ADDR_W = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  tew_pkg::pos_info_t          info_in,
    input  logic                        bit_in,
    input  logic [ADDR_W-1:0]           addr_in,
    input  logic                        fwd_hit_in,
    input  logic [tew_pkg::LINE_W-1:0]  fwd_data_in,
    input  logic [tew_pkg::LINE_W-1:0]  rd_data,
    input  logic [1:0]                  select_kind,
    input  logic [7:0]                  direction_mask,
    output logic                        in_ready,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [tew_pkg::LINE_W-1:0]  wr_data,
    tew_res_if.source                   res
);
    import tew_pkg::*;

    // Stage one: item waiting for its line store word
    logic              s1_valid_reg, s1_valid_next;
    pos_info_t         s1_info_reg;
    logic              s1_bit_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_fwd_hit_reg;
    logic [LINE_W-1:0] s1_fwd_data_reg;
    logic              s1_adv;

    logic [LINE_W-1:0] line;
    logic [8:0]        win_reg, win_next;
    logic              centre, inner, ok;
    logic [7:0]        diff, cut, mask;
    logic [3:0]        cnt, count;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic              out_matched_reg, out_inner_reg, out_last_reg;
    logic [7:0]        out_mask_reg;
    logic [3:0]        out_count_reg;

    // Flow control: an item without a result never waits for the output
    assign s1_adv   = s1_valid_reg && (!s1_info_reg.res_valid || !out_valid_reg || res.ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        if (load)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_info_reg    <= '0;
            s1_fwd_hit_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (load)
            begin
                s1_info_reg    <= info_in;
                s1_fwd_hit_reg <= fwd_hit_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_bit_reg      <= bit_in;
            s1_addr_reg     <= addr_in;
            s1_fwd_data_reg <= fwd_data_in;
        end
    end

    // Line store word, bypassed when its write was still in flight
    assign line     = s1_fwd_hit_reg ? s1_fwd_data_reg : rd_data;
    assign win_next = {s1_bit_reg, line[0], line[1], win_reg[8:3]};

    // Shift the middle row up, new flag becomes the middle row
    assign wr_en   = s1_adv;
    assign wr_addr = s1_addr_reg;
    assign wr_data = {line[0], s1_bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_adv)
            win_reg <= win_next;
    end

    // Neighbour test: order UL,U,UR,L,R,DL,D,DR
    always_comb
    begin
        centre = win_next[4];
        inner  = !centre;
        diff   = {win_next[8], win_next[5], win_next[2], win_next[7],
                  win_next[1], win_next[6], win_next[3], win_next[0]} ^ {8{centre}};
        cut[0] = s1_info_reg.top_cut | s1_info_reg.left_cut;
        cut[1] = s1_info_reg.top_cut;
        cut[2] = s1_info_reg.top_cut | s1_info_reg.right_cut;
        cut[3] = s1_info_reg.left_cut;
        cut[4] = s1_info_reg.right_cut;
        cut[5] = s1_info_reg.bot_cut | s1_info_reg.left_cut;
        cut[6] = s1_info_reg.bot_cut;
        cut[7] = s1_info_reg.bot_cut | s1_info_reg.right_cut;
        mask   = diff & ~cut;

        cnt = '0;
        for (int k = 0; k < 8; k++)
        begin
            cnt = cnt + {3'b000, mask[k]};
        end
        count = inner ? (FULL_COUNT - cnt) : cnt;

        ok = (select_kind == SEL_BOTH) ||
             ((select_kind == SEL_INNER) && inner) ||
             ((select_kind == SEL_OUTER) && !inner);
    end

    // Result register
    always_comb
    begin
        if (s1_adv && s1_info_reg.res_valid)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_info_reg.res_valid)
        begin
            out_matched_reg <= ok && ((direction_mask & mask) != 8'h00);
            out_inner_reg   <= inner;
            out_mask_reg    <= mask;
            out_count_reg   <= count;
            out_last_reg    <= s1_info_reg.last;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.matched        = out_matched_reg;
    assign res.inner          = out_inner_reg;
    assign res.neighbour_mask = out_mask_reg;
    assign res.edge_count     = out_count_reg;
    assign res.last           = out_last_reg;

endmodule

// ===== design/transparency_edge_window.sv =====
// Transparency edge window. Takes one transparency flag per clock in raster order
// barring output stalls, and returns, for each pixel, its inner/outer kind, the mask
// of opposite-kind neighbours in its 3x3 window and their count (nine minus it for
// inner pixels), and a match flag. A pixel's result comes out W+1 items after the
// pixel (W = image width), so after the frame W+1 flush items drain the last
// results; a flush opening a frame is dropped. Both line stores share one RAM word
// per column, read at acceptance and written back as the item leaves the read
// stage, and that single read port plus single write port sets the rate. A result
// is loaded into the output register at the clock edge after the transfer of the
// item that completes it, unless the previous result is still waiting. Writing the
// width or height restarts the frame. The line stores need no clearing after reset.
module transparency_edge_window #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tew_pix_if.sink                         pix,
    tew_res_if.source                       res,
    input  logic                            cfg_we,
    input  logic [tew_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tew_pkg::CFG_W-1:0]       cfg_data
);
    import tew_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Configuration registers
    logic [CFG_W-1:0] width_reg, width_next, height_reg, height_next;
    logic [1:0]       select_reg, select_next;
    logic [7:0]       dir_reg, dir_next;
    logic             restart;

    logic              accept, acc_item, ignore, w_is_one, bit_in, cls_ready;
    logic [COL_W-1:0]  col;
    pos_info_t         info;
    logic              wr_en, fwd_hit;
    logic [COL_W-1:0]  wr_addr;
    logic [LINE_W-1:0] wr_data, rd_data;

    // Register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        select_next = select_reg;
        dir_next    = dir_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data;
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data;
                    restart     = 1'b1;
                end
                REG_SELECT_KIND:    select_next = cfg_data[1:0];
                REG_DIRECTION_MASK: dir_next    = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            select_reg <= SELECT_RST;
            dir_reg    <= DIR_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            select_reg <= select_next;
            dir_reg    <= dir_next;
        end
    end

    // Input transfer
    assign pix.ready = cls_ready;
    assign accept    = pix.valid && pix.ready;
    assign acc_item  = accept && !ignore;
    assign bit_in    = pix.kind | pix.transparent;

    tew_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .step         (accept),
        .flush        (pix.kind),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col          (col),
        .ignore       (ignore),
        .w_is_one     (w_is_one),
        .info         (info)
    );

    // Both line stores, one word per column
    tew_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (acc_item),
        .raddr (col),
        .rdata (rd_data)
    );

    // Read and write of the same column in one cycle: take the word being written
    assign fwd_hit = wr_en && (wr_addr == col);

    tew_classify #(
        .ADDR_W (COL_W)
    ) u_classify (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (acc_item),
        .info_in        (info),
        .bit_in         (bit_in),
        .addr_in        (col),
        .fwd_hit_in     (fwd_hit),
        .fwd_data_in    (wr_data),
        .rd_data        (rd_data),
        .select_kind    (select_reg),
        .direction_mask (dir_reg),
        .in_ready       (cls_ready),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .res            (res)
    );

    // Same-column overlap only arises on one-pixel rows or at the wrap to a new frame
    a_fwd_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        acc_item && fwd_hit |-> w_is_one || (col == '0))
        else $error("forwarding hit away from column zero on a wide row");

    // Last pixel of the frame has no right or lower neighbours
    a_last_cut: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last |-> res.neighbour_mask[7:4] == 4'b0000)
        else $error("last result marks a neighbour outside the frame");

    // Count agrees with the mask for outer centres
    a_outer_count: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.inner |-> res.edge_count == 4'($countones(res.neighbour_mask)))
        else $error("outer count differs from mask");

    // Count agrees with the mask for inner centres
    a_inner_count: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.inner |->
            res.edge_count == FULL_COUNT - 4'($countones(res.neighbour_mask)))
        else $error("inner count differs from mask");

    // A match needs a selected direction marked
    a_match_dir: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.matched |-> (res.neighbour_mask & dir_reg) != 8'h00)
        else $error("match without a selected direction");

endmodule

// ===== tb/tb_transparency_edge_window.sv =====
// Self-checking testbench for transparency_edge_window: raster frames of
// transparency flags in, 3x3 edge classifications out, checked in order.
// Depends on tew_pkg, the tew_pix_if / tew_res_if channels and the block itself.
`timescale 1ns / 1ps

module tb_transparency_edge_window;
    import tew_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 250;

    // Index past the register list; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic       matched;
        logic       inner;
        logic [7:0] neighbour_mask;
        logic [3:0] edge_count;
        logic       last;
    } edge_result_t;

    // Edge window predictor and in-order result checker
    class edge_window_checker;
        bit                upper_row [MAX_W];
        bit                middle_row [MAX_W];
        bit [8:0]          window;
        int unsigned       col_pos;
        int unsigned       row_pos;
        logic [CFG_W-1:0]  width_reg;
        logic [CFG_W-1:0]  height_reg;
        logic [1:0]        select_reg;
        logic [7:0]        dir_reg;
        edge_result_t      pending_edges [$];
        int                errors;
        int                items;
        int                dropped;
        int                results;
        int                match_count;
        int                frame_ends;

        function new();
            window      = '0;
            col_pos     = 0;
            row_pos     = 0;
            width_reg   = WIDTH_RST;
            height_reg  = HEIGHT_RST;
            select_reg  = SELECT_RST;
            dir_reg     = DIR_RST;
            errors      = 0;
            items       = 0;
            dropped     = 0;
            results     = 0;
            match_count = 0;
            frame_ends  = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == '0)
                return 1;
            if (int'(width_reg) > MAX_W)
                return MAX_W;
            return int'(width_reg);
        endfunction

        function int unsigned eff_height();
            if (height_reg == '0)
                return 1;
            if (int'(height_reg) > MAX_H)
                return MAX_H;
            return int'(height_reg);
        endfunction

        function bit at_frame_start();
            return col_pos == 0 && row_pos == 0;
        endfunction

        function int pending();
            return pending_edges.size();
        endfunction

        // Mirror of a register write; geometry writes restart the frame
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:
                begin
                    width_reg = data;
                    col_pos   = 0;
                    row_pos   = 0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_reg = data;
                    col_pos    = 0;
                    row_pos    = 0;
                end
                REG_SELECT_KIND:    select_reg = data[1:0];
                REG_DIRECTION_MASK: dir_reg = data[7:0];
                default: ;
            endcase
        endfunction

        // Advance the window by one accepted input and queue the result it completes
        function void predict_pixel(bit flush, bit transp);
            int unsigned  w, h, c, r, idx, cx, cnt, col, row, pos;
            int           cy, k;
            bit           b, centre, inner, ok;
            bit [2:0]     triple;
            bit [7:0]     nmask;
            edge_result_t res;

            w = eff_width();
            h = eff_height();
            c = col_pos;
            r = row_pos;

            // flush at the first position of a frame is dropped outright
            if (flush && r == 0 && c == 0)
            begin
                dropped++;
                return;
            end
            items++;

            b      = flush ? 1'b1 : transp;
            idx    = (c < MAX_W) ? c : 0;
            triple = {b, middle_row[idx], upper_row[idx]};
            upper_row[idx]  = middle_row[idx];
            middle_row[idx] = b;
            window = {triple, window[8:3]};

            // centre sits one row up and one column left; wraps at column zero
            if (c >= 1)
            begin
                cx = c - 1;
                cy = int'(r) - 1;
            end
            else
            begin
                cx = w - 1;
                cy = int'(r) - 2;
            end

            if (cy >= 0 && cy < int'(h))
            begin
                centre = window[4];
                nmask  = '0;
                cnt    = 0;
                for (k = 0; k < 8; k++)
                begin
                    pos = (k < 4) ? k : k + 1;
                    col = pos % 3;
                    row = pos / 3;
                    // neighbours outside the frame are never marked
                    if (row == 0 && cy == 0)
                        continue;
                    if (row == 2 && cy == int'(h) - 1)
                        continue;
                    if (col == 0 && cx == 0)
                        continue;
                    if (col == 2 && cx == w - 1)
                        continue;
                    if (window[col * 3 + row] != centre)
                    begin
                        nmask[k] = 1'b1;
                        cnt++;
                    end
                end
                inner = ~centre;
                if (inner)
                    cnt = int'(FULL_COUNT) - cnt;
                ok = (select_reg == SEL_BOTH) ||
                     (select_reg == SEL_INNER && inner) ||
                     (select_reg == SEL_OUTER && !inner);
                res.matched        = ok && ((dir_reg & nmask) != 8'h00);
                res.inner          = inner;
                res.neighbour_mask = nmask;
                res.edge_count     = 4'(cnt);
                res.last           = (cy == int'(h) - 1) && (cx == w - 1);
                pending_edges.push_back(res);
            end

            if (r >= h + 1 && c == 0)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            else
            begin
                c++;
                if (c >= w)
                begin
                    c = 0;
                    r++;
                end
                col_pos = c;
                row_pos = r;
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // Compare one output transfer against the oldest prediction
        function void check_result(edge_result_t got);
            edge_result_t want;
            if (pending_edges.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_edges.pop_front();
            results++;
            if (want.matched)
                match_count++;
            if (want.last)
                frame_ends++;
            compare_field("matched", 8'(want.matched), 8'(got.matched));
            compare_field("inner", 8'(want.inner), 8'(got.inner));
            compare_field("neighbour_mask", want.neighbour_mask, got.neighbour_mask);
            compare_field("edge_count", 8'(want.edge_count), 8'(got.edge_count));
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tew_pix_if pix_ch ();
    tew_res_if res_ch ();

    edge_window_checker checker_h = new();

    // Idling controls: sender and receiver both draw gaps while idle_on is set; hold_request holds only the receiver
    bit idle_on    = 1'b0;
    int hold_request = 0;
    int geometry_writes = 0;

    transparency_edge_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input logic flush, input logic transp);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 15)) : 0;
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.kind        <= flush;
        pix_ch.transparent <= transp;
        do @(posedge clk); while (pix_ch.ready !== 1'b1);
        checker_h.predict_pixel(flush, transp);
    endtask

    // Stop offering, wait for every predicted result, then let the pipe empty
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        checker_h.write_reg(idx, CFG_W'(value));
        @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        geometry_writes++;
    endtask

    // Whole frame plus trailing drain; noisy mode mixes in flushes and late pixels
    task automatic send_frame(input int unsigned dens, input bit noisy);
        int unsigned w, h, n;
        if (!checker_h.at_frame_start())
        begin
            settle();
            write_reg(REG_IMAGE_WIDTH, int'(checker_h.width_reg));
        end
        w = checker_h.eff_width();
        h = checker_h.eff_height();
        for (n = 0; n < w * h; n++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_item(KIND_FLUSH, 1'($urandom_range(0, 1)));
            else
                send_item(KIND_PIXEL, $urandom_range(0, 99) < dens);
        end
        for (n = 0; n <= w; n++)
        begin
            if (noisy && $urandom_range(0, 1) == 1)
                send_item(KIND_PIXEL, 1'($urandom_range(0, 1)));
            else
                send_item(KIND_FLUSH, 1'($urandom_range(0, 1)));
        end
    endtask

    // Result receiver: random stalls, plus the long hold when asked for
    initial
    begin : result_sink
        int           stall;
        edge_result_t got;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else
                stall = idle_on ? int'($urandom_range(0, 15)) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            got.matched        = res_ch.matched;
            got.inner          = res_ch.inner;
            got.neighbour_mask = res_ch.neighbour_mask;
            got.edge_count     = res_ch.edge_count;
            got.last           = res_ch.last;
            checker_h.check_result(got);
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned n, w, h, phase, dens, random_base;
        bit [8:0]    pattern;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_IMAGE_WIDTH;
        cfg_data           <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.kind        <= KIND_PIXEL;
        pix_ch.transparent <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame: spare register write, dropped leading flush,
        // flush inside the frame, pixels and flushes past the frame
        idle_on = 1'b1;
        write_reg(REG_SPARE, 13'h1fff);
        set_geometry(3, 3);
        send_item(KIND_FLUSH, 1'b1);
        pattern = 9'b101_010_110;
        for (n = 0; n < 9; n++)
        begin
            if (n == 6)
                send_item(KIND_FLUSH, 1'b0);
            else
                send_item(KIND_PIXEL, pattern[n]);
        end
        send_item(KIND_PIXEL, 1'b0);
        send_item(KIND_PIXEL, 1'b1);
        send_item(KIND_FLUSH, 1'b0);
        send_item(KIND_FLUSH, 1'b1);

        // zero width and height clamp to a single pixel; nothing selected
        set_geometry(0, 0);
        write_reg(REG_SELECT_KIND, 0);
        send_item(KIND_PIXEL, 1'b0);
        send_item(KIND_FLUSH, 1'b0);
        send_item(KIND_FLUSH, 1'b1);

        // inner only, but no direction enabled
        set_geometry(2, 1);
        write_reg(REG_SELECT_KIND, int'(SEL_INNER));
        write_reg(REG_DIRECTION_MASK, 0);
        send_item(KIND_PIXEL, 1'b0);
        send_item(KIND_PIXEL, 1'b1);
        for (n = 0; n < 3; n++)
            send_item(KIND_FLUSH, 1'($urandom_range(0, 1)));

        // Medium frame and a tall one-pixel column, no idling
        idle_on = 1'b0;
        set_geometry(20, 4);
        settle();
        write_reg(REG_SELECT_KIND, int'(SEL_BOTH));
        write_reg(REG_DIRECTION_MASK, 8'hff);
        send_frame(50, 1'b0);
        set_geometry(1, 40);
        send_frame(30, 1'b0);

        // Receiver holds off while the sender keeps offering
        set_geometry(32, 6);
        hold_request = HOLD_CYCLES;
        send_frame(50, 1'b0);

        // Random frames, with broken sequences and noise mixed in
        random_base = checker_h.items;
        while (checker_h.items < random_base + RANDOM_ITEMS)
        begin
            phase   = $urandom_range(0, 9);
            idle_on = $urandom_range(0, 3) != 0;

            if (phase < 3 || !checker_h.at_frame_start())
            begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) :
                                                  $urandom_range(1, 12);
                h = $urandom_range(1, 8);
                if ($urandom_range(0, 15) == 0)
                    w = 0;
                if ($urandom_range(0, 15) == 0)
                    h = 0;
                set_geometry(w, h);
            end

            if ($urandom_range(0, 3) == 0)
            begin
                settle();
                write_reg(REG_SELECT_KIND, $urandom_range(0, 3));
                case ($urandom_range(0, 2))
                    0:       write_reg(REG_DIRECTION_MASK, 8'hff);
                    1:       write_reg(REG_DIRECTION_MASK, 1 << $urandom_range(0, 7));
                    default: write_reg(REG_DIRECTION_MASK, $urandom_range(0, 255));
                endcase
            end

            case ($urandom_range(0, 4))
                0:       dens = 0;
                1:       dens = 100;
                2:       dens = $urandom_range(5, 20);
                default: dens = $urandom_range(0, 100);
            endcase

            w = checker_h.eff_width();
            h = checker_h.eff_height();
            if (phase <= 6)
                send_frame(dens, 1'b0);
            else if (phase == 7)
                send_frame(dens, 1'b1);
            else if (phase == 8)
            begin
                // frame cut short; the next pass restarts it
                for (n = $urandom_range(1, w * h + w); n > 0; n--)
                    send_item(KIND_PIXEL, $urandom_range(0, 99) < dens);
            end
            else
            begin
                for (n = $urandom_range(5, 40); n > 0; n--)
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end

        settle();
        $display("Run covered %0d items (%0d leading flushes dropped), %0d results checked,",
                 checker_h.items, checker_h.dropped, checker_h.results);
        $display("%0d matched, %0d frame ends, %0d geometry settings, %0d mismatches.",
                 checker_h.match_count, checker_h.frame_ends, geometry_writes,
                 checker_h.errors);
        if (checker_h.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
